// ----- design/vrp_pkg.sv -----
`default_nettype none
package vrp_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int COORD_BITS = 32;
	localparam int QBITS = 30;
	localparam int CORDIC_STEPS = 30;
	localparam int NUM_AXES = 3;
	// angle regs to matrix regs: init, cordic steps, sign fix, two quaternion, two matrix
	localparam int SETTLE_CYCLES = CORDIC_STEPS + 8;
	localparam int SETTLE_W = $clog2(SETTLE_CYCLES + 1);
	localparam int CFG_IDX_W = 3;

	typedef logic signed [35:0] qv_t;
	typedef logic signed [33:0] cz_t;

	localparam qv_t CORDIC_GAIN = 36'sd652032874;

	localparam cz_t ATAN_TURN [CORDIC_STEPS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
		34'sd21354465, 34'sd10679838, 34'sd5340245, 34'sd2670163, 34'sd1335087,
		34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722,
		34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
		34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41,
		34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANGLE_X  = 3'd0,
		CFG_ANGLE_Y  = 3'd1,
		CFG_ANGLE_Z  = 3'd2,
		CFG_OFFSET_X = 3'd3,
		CFG_OFFSET_Y = 3'd4
	} cfg_idx_e;

	localparam logic CMD_OFFSET = 1'b0;
	localparam logic CMD_RAW = 1'b1;

	typedef struct packed {
		logic command;
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] point_z;
	} vertex_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] screen_x;
		logic signed [COORD_BITS-1:0] screen_y;
	} result_t;

	// rounded q30 product
	function automatic qv_t mulq(input qv_t a, input qv_t b);
		logic signed [71:0] p;
		p = a * b + (72'sd1 <<< (QBITS - 1));
		return qv_t'(p >>> QBITS);
	endfunction

endpackage
`default_nettype wire

// ----- design/vertex_rotate_project_top.sv -----
`default_nettype none
// vertex rotate and orthographic project
// start with vertex holds one item; it is taken at a clock edge with start high
// and busy low. the rotated and projected item appears on result for exactly
// one cycle with done high, after the vtx_s1, prod_s2, rx_s3 and result_s4 registers;
// one item can be taken every cycle while busy is low; the receiver cannot stall the output.
// the rotation matrix is built from the angle registers by a free running
// chain of 36 register stages: phase setup, 30 cordic steps, sign fix, three
// multiply stages and a matrix add stage. any config write (and reset) holds
// busy high, by reloading the settle count, while that chain settles.
// config: cfg_we, cfg_index, cfg_data write one register per edge, no wait.
// command 0 adds the offset registers, command 1 leaves them out; both results
// saturate to signed 32 bits.
// reset clears the angle and offset registers to zero, drops all in-flight
// items and starts the settle count.
module vertex_rotate_project_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire vrp_pkg::vertex_t               vertex,
	output logic                                done,
	output vrp_pkg::result_t                    result,
	input  wire logic                           cfg_we,
	input  wire logic [vrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                    cfg_data
);
	import vrp_pkg::*;

	logic [ANGLE_BITS-1:0] angle_q [NUM_AXES];
	logic signed [COORD_BITS-1:0] offset_x_q, offset_y_q;
	logic [SETTLE_W-1:0] settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) angle_q[a] <= '0;
			offset_x_q <= '0;
			offset_y_q <= '0;
			settle_q <= SETTLE_W'(SETTLE_CYCLES);
		end else begin
			if (cfg_we) begin
				settle_q <= SETTLE_W'(SETTLE_CYCLES);
				case (cfg_index)
					CFG_ANGLE_X: angle_q[0] <= cfg_data[ANGLE_BITS-1:0];
					CFG_ANGLE_Y: angle_q[1] <= cfg_data[ANGLE_BITS-1:0];
					CFG_ANGLE_Z: angle_q[2] <= cfg_data[ANGLE_BITS-1:0];
					CFG_OFFSET_X: offset_x_q <= cfg_data;
					CFG_OFFSET_Y: offset_y_q <= cfg_data;
					default: ;
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
		end
	end

	assign busy = (settle_q != '0);

	// matrix chain: cordic stages per axis
	qv_t cx_s [NUM_AXES][CORDIC_STEPS+1];
	qv_t cy_s [NUM_AXES][CORDIC_STEPS+1];
	cz_t cz_s [NUM_AXES][CORDIC_STEPS+1];
	logic flip_s [NUM_AXES][CORDIC_STEPS+1];
	qv_t cos_s, sin_s;
	qv_t c_f [NUM_AXES];
	qv_t s_f [NUM_AXES];

	always_ff @(posedge clk) begin
		for (int a = 0; a < NUM_AXES; a++) begin
			// half-angle phase, folded into the right half plane
			flip_s[a][0] <= angle_q[a][ANGLE_BITS-1];
			cx_s[a][0] <= CORDIC_GAIN;
			cy_s[a][0] <= '0;
			cz_s[a][0] <= cz_t'({angle_q[a], (31 - ANGLE_BITS)'(0)})
				- (angle_q[a][ANGLE_BITS-1] ? 34'sh80000000 : 34'sd0);
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				flip_s[a][i+1] <= flip_s[a][i];
				if (cz_s[a][i] >= 0) begin
					cx_s[a][i+1] <= cx_s[a][i] - (cy_s[a][i] >>> i);
					cy_s[a][i+1] <= cy_s[a][i] + (cx_s[a][i] >>> i);
					cz_s[a][i+1] <= cz_s[a][i] - ATAN_TURN[i];
				end else begin
					cx_s[a][i+1] <= cx_s[a][i] + (cy_s[a][i] >>> i);
					cy_s[a][i+1] <= cy_s[a][i] - (cx_s[a][i] >>> i);
					cz_s[a][i+1] <= cz_s[a][i] + ATAN_TURN[i];
				end
			end
			c_f[a] <= flip_s[a][CORDIC_STEPS] ? -cx_s[a][CORDIC_STEPS] : cx_s[a][CORDIC_STEPS];
			s_f[a] <= flip_s[a][CORDIC_STEPS] ? -cy_s[a][CORDIC_STEPS] : cy_s[a][CORDIC_STEPS];
		end
	end

	assign cos_s = c_f[2];
	assign sin_s = s_f[2];

	// quaternion and matrix stages
	qv_t cxcy_q, sxsy_q, sxcy_q, cxsy_q, cz_q, sz_q;
	qv_t qw_q, qx_q, qy_q, qz_q;
	qv_t ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
	qv_t m_q [2][3];

	always_ff @(posedge clk) begin
		cxcy_q <= mulq(c_f[0], c_f[1]);
		sxsy_q <= mulq(s_f[0], s_f[1]);
		sxcy_q <= mulq(s_f[0], c_f[1]);
		cxsy_q <= mulq(c_f[0], s_f[1]);
		cz_q <= cos_s;
		sz_q <= sin_s;

		qw_q <= mulq(cxcy_q, cz_q) - mulq(sxsy_q, sz_q);
		qx_q <= mulq(sxcy_q, cz_q) + mulq(cxsy_q, sz_q);
		qy_q <= mulq(cxsy_q, cz_q) - mulq(sxcy_q, sz_q);
		qz_q <= mulq(sxsy_q, cz_q) + mulq(cxcy_q, sz_q);

		ww_q <= mulq(qw_q, qw_q);
		xx_q <= mulq(qx_q, qx_q);
		yy_q <= mulq(qy_q, qy_q);
		zz_q <= mulq(qz_q, qz_q);
		xy_q <= mulq(qx_q, qy_q);
		wz_q <= mulq(qw_q, qz_q);
		xz_q <= mulq(qx_q, qz_q);
		wy_q <= mulq(qw_q, qy_q);
		yz_q <= mulq(qy_q, qz_q);
		wx_q <= mulq(qw_q, qx_q);

		m_q[0][0] <= ww_q + xx_q - yy_q - zz_q;
		m_q[0][1] <= (xy_q - wz_q) <<< 1;
		m_q[0][2] <= (xz_q + wy_q) <<< 1;
		m_q[1][0] <= (xy_q + wz_q) <<< 1;
		m_q[1][1] <= ww_q - xx_q + yy_q - zz_q;
		m_q[1][2] <= (yz_q - wx_q) <<< 1;
	end

	// item pipeline
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	vertex_t vtx_s1;
	logic cmd_s2, cmd_s3;
	logic signed [67:0] prod_s2 [2][3];
	logic signed [39:0] rx_s3, ry_s3;
	logic signed [69:0] sum_x, sum_y;
	logic signed [40:0] fx, fy;
	result_t result_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		sum_x = 70'(prod_s2[0][0]) + 70'(prod_s2[0][1]) + 70'(prod_s2[0][2])
			+ (70'sd1 <<< (QBITS - 1));
		sum_y = 70'(prod_s2[1][0]) + 70'(prod_s2[1][1]) + 70'(prod_s2[1][2])
			+ (70'sd1 <<< (QBITS - 1));
		fx = 41'(rx_s3) + ((cmd_s3 == CMD_OFFSET) ? 41'(offset_x_q) : 41'sd0);
		fy = 41'(ry_s3) + ((cmd_s3 == CMD_OFFSET) ? 41'(offset_y_q) : 41'sd0);
	end

	always_ff @(posedge clk) begin
		vtx_s1 <= vertex;
		cmd_s2 <= vtx_s1.command;
		for (int r = 0; r < 2; r++) begin
			prod_s2[r][0] <= m_q[r][0] * vtx_s1.point_x;
			prod_s2[r][1] <= m_q[r][1] * vtx_s1.point_y;
			prod_s2[r][2] <= m_q[r][2] * vtx_s1.point_z;
		end
		cmd_s3 <= cmd_s2;
		rx_s3 <= 40'(sum_x >>> QBITS);
		ry_s3 <= 40'(sum_y >>> QBITS);
		if (fx > 41'sd2147483647) result_s4.screen_x <= 32'sh7fffffff;
		else if (fx < -41'sd2147483648) result_s4.screen_x <= 32'sh80000000;
		else result_s4.screen_x <= fx[31:0];
		if (fy > 41'sd2147483647) result_s4.screen_y <= 32'sh7fffffff;
		else if (fy < -41'sd2147483648) result_s4.screen_y <= 32'sh80000000;
		else result_s4.screen_y <= fy[31:0];
	end

	assign done = valid_s4;
	assign result = result_s4;

endmodule
`default_nettype wire

// ----- tb/vertex_rotate_project_top_tb.sv -----
`default_nettype none
module vertex_rotate_project_top_tb;
	import vrp_pkg::*;

	localparam longint ATAN_TAB [30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	vertex_t vertex = '0;
	logic done;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	vertex_rotate_project_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .vertex(vertex),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor copy of the registers
	logic [15:0] ang_x = '0, ang_y = '0, ang_z = '0;
	logic signed [31:0] off_x = '0, off_y = '0;

	vertex_t pending_vertices [$];
	int gap_lens [$];
	result_t expected_screens [$];
	int errors = 0;
	int checked = 0;
	bit feeding_done = 1'b0;
	// item taken at the last rising edge
	bit took = 1'b0;

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic void half_cos_sin(input logic [15:0] ang, output longint c,
			output longint s);
		longint x, y, z, nx;
		logic [31:0] phase;
		bit flip;
		phase = {1'b0, ang, 15'b0};
		z = longint'(phase);
		x = 652032874;
		y = 0;
		flip = 0;
		if (phase >= 32'h4000_0000) begin
			z -= 64'sh8000_0000;
			flip = 1;
		end
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				nx = x - shr(y, i);
				y = y + shr(x, i);
				z -= ATAN_TAB[i];
			end else begin
				nx = x + shr(y, i);
				y = y - shr(x, i);
				z += ATAN_TAB[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic result_t project_vertex(vertex_t v);
		longint cx, sx, cy, sy, cz, sz, qw, qx, qy, qz;
		longint m00, m01, m02, m10, m11, m12, rx, ry, px, py, pz;
		result_t r;
		half_cos_sin(ang_x, cx, sx);
		half_cos_sin(ang_y, cy, sy);
		half_cos_sin(ang_z, cz, sz);
		qw = qmul(qmul(cx, cy), cz) - qmul(qmul(sx, sy), sz);
		qx = qmul(qmul(sx, cy), cz) + qmul(qmul(cx, sy), sz);
		qy = qmul(qmul(cx, sy), cz) - qmul(qmul(sx, cy), sz);
		qz = qmul(qmul(sx, sy), cz) + qmul(qmul(cx, cy), sz);
		m00 = qmul(qw, qw) + qmul(qx, qx) - qmul(qy, qy) - qmul(qz, qz);
		m01 = 2 * (qmul(qx, qy) - qmul(qw, qz));
		m02 = 2 * (qmul(qx, qz) + qmul(qw, qy));
		m10 = 2 * (qmul(qx, qy) + qmul(qw, qz));
		m11 = qmul(qw, qw) - qmul(qx, qx) + qmul(qy, qy) - qmul(qz, qz);
		m12 = 2 * (qmul(qy, qz) - qmul(qw, qx));
		px = v.point_x;
		py = v.point_y;
		pz = v.point_z;
		// sums fit in 64 bits: a matrix row has unit length in q30, |p| <= 2^31
		rx = (m00 * px + m01 * py + m02 * pz + (64'sd1 <<< 29)) >>> 30;
		ry = (m10 * px + m11 * py + m12 * pz + (64'sd1 <<< 29)) >>> 30;
		if (v.command == CMD_OFFSET) begin
			rx += off_x;
			ry += off_y;
		end
		r.screen_x = clamp32(rx);
		r.screen_y = clamp32(ry);
		return r;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			default: return $urandom();
		endcase
	endfunction

	// driver
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (took) begin
				pending_vertices.pop_front();
				gap_lens.pop_front();
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_vertices.size() > 0) begin
				if (gap_lens[0] > 0 && !(start && !took)) begin
					gap_left <= gap_lens[0] - 1;
					gap_lens[0] = 0;
					start <= 1'b0;
				end else begin
					vertex <= pending_vertices[0];
					start <= 1'b1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// accepted items get their prediction at the accepting edge
	always @(posedge clk) begin
		took = arst_n && start && !busy;
		if (took)
			expected_screens.push_back(project_vertex(vertex));
		if (arst_n && done) begin
			if (expected_screens.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				errors++;
			end else begin
				result_t e;
				e = expected_screens.pop_front();
				checked++;
				if (e.screen_x !== result.screen_x) begin
					$display("%0t: screen_x expected %h actual %h", $time,
						e.screen_x, result.screen_x);
					errors++;
				end
				if (e.screen_y !== result.screen_y) begin
					$display("%0t: screen_y expected %h actual %h", $time,
						e.screen_y, result.screen_y);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ANGLE_X: ang_x = data[15:0];
			CFG_ANGLE_Y: ang_y = data[15:0];
			CFG_ANGLE_Z: ang_z = data[15:0];
			CFG_OFFSET_X: off_x = data;
			CFG_OFFSET_Y: off_y = data;
			default: ;
		endcase
	endtask

	task automatic queue_vertex(input logic cmd, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input int gap);
		vertex_t v;
		v.command = cmd;
		v.point_x = x;
		v.point_y = y;
		v.point_z = z;
		pending_vertices.push_back(v);
		gap_lens.push_back(gap);
	endtask

	task automatic drain();
		wait (pending_vertices.size() == 0 && !start);
		wait (expected_screens.size() == 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_all(input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
			input logic [31:0] ox, input logic [31:0] oy);
		write_reg(CFG_ANGLE_X, ax);
		write_reg(CFG_ANGLE_Y, ay);
		write_reg(CFG_ANGLE_Z, az);
		write_reg(CFG_OFFSET_X, ox);
		write_reg(CFG_OFFSET_Y, oy);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// directed: identity rotation, extremes, both commands
		queue_vertex(CMD_OFFSET, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0);
		queue_vertex(CMD_RAW, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
		queue_vertex(CMD_OFFSET, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1);
		queue_vertex(CMD_RAW, 0, 0, 0, 0);
		queue_vertex(CMD_OFFSET, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
		drain();
		// offsets at the extremes drive saturation
		set_all(32'h4000, 32'h2000, 32'hffff, 32'h7fff_ffff, 32'h8000_0000);
		for (int i = 0; i < 8; i++)
			queue_vertex(i[0], i[1] ? 32'h7fff_ffff : 32'h8000_0000,
				i[2] ? 32'h7fff_ffff : 32'h8000_0000, 32'h7fff_ffff, 0);
		drain();
		set_all(32'h8000, 32'hc000, 32'h0001, 32'h8000_0000, 32'h7fff_ffff);
		for (int i = 0; i < 6; i++)
			queue_vertex(i[0], pick_coord(), pick_coord(), pick_coord(), 0);
		drain();
		// random phases with random settings
		for (int ph = 0; ph < 10; ph++) begin
			set_all($urandom(), $urandom(), $urandom(),
				ph[0] ? $urandom() : ($urandom_range(0, 32'h0020_0000) - 32'h0010_0000),
				ph[1] ? $urandom() : ($urandom_range(0, 32'h0020_0000) - 32'h0010_0000));
			for (int i = 0; i < 82; i++)
				queue_vertex(1'($urandom_range(0, 1)), pick_coord(), pick_coord(),
					pick_coord(), (ph % 3 == 0) ? 0 : pick_gap());
			drain();
		end
		$display("checked %0d results over 13 register settings", checked);
		$display("angle and offset extremes and saturation included");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
design/vrp_pkg.sv
design/vertex_rotate_project_top.sv
tb/vertex_rotate_project_top_tb.sv
